[sv/adler64_word_checksum_macros.svh]
// ----------------------------------------------------------------------------
// adler64_word_checksum_macros.svh
// Assertion macros used by the checksum top level.
// ----------------------------------------------------------------------------
`ifndef ADLER64_WORD_CHECKSUM_MACROS_SVH
`define ADLER64_WORD_CHECKSUM_MACROS_SVH

// Invariant checked at every clock edge outside reset.
`define ADL64_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ADL64_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error(msg);

`endif

[sv/adl64_pkg.sv]
// ----------------------------------------------------------------------------
// adl64_pkg
// Widths, moduli and types of the 64-bit word checksum.
// ----------------------------------------------------------------------------
package adl64_pkg;

	localparam int WORD_W = 32;
	localparam int SEED_W = 64;
	localparam int LOW_W  = 33;
	localparam int HIGH_W = 31;

	// Low sum modulus, just below 1.5 * 2^32
	localparam logic [LOW_W-1:0]  LOW_MOD  = 33'd6442450941;
	// High sum modulus, 2^31 - 1
	localparam logic [HIGH_W-1:0] HIGH_MOD = 31'h7fff_ffff;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              first;
		logic [SEED_W-1:0] seed;
		logic              last;
	} word_item_t;

	typedef struct packed {
		logic [HIGH_W-1:0] high;
		logic [LOW_W-1:0]  low;
	} sums_t;

	// Output register control from the stage that feeds it
	typedef struct packed {
		logic load;
		logic free;
	} out_ctl_t;

endpackage

[sv/adl64_word_if.sv]
// ----------------------------------------------------------------------------
// adl64_word_if
// Input channel: one data word per transaction with framing and seed.
// ----------------------------------------------------------------------------
interface adl64_word_if;
	import adl64_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] word;
	logic              first;
	logic [SEED_W-1:0] seed;
	logic              last;

	modport source (output valid, word, first, seed, last, input ready);
	modport sink   (input valid, word, first, seed, last, output ready);
endinterface

[sv/adl64_sum_if.sv]
// ----------------------------------------------------------------------------
// adl64_sum_if
// Output channel: one 64-bit checksum per transaction.
// ----------------------------------------------------------------------------
interface adl64_sum_if;
	import adl64_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [HIGH_W+LOW_W-1:0]  checksum;

	modport source (output valid, checksum, input ready);
	modport sink   (input valid, checksum, output ready);
endinterface

[sv/adl64_sum_update.sv]
// ----------------------------------------------------------------------------
// adl64_sum_update
// Next low and high sums for one word, with optional seed load.
// ----------------------------------------------------------------------------
module adl64_sum_update (
	input  adl64_pkg::word_item_t item,
	input  adl64_pkg::sums_t      cur,
	output adl64_pkg::sums_t      nxt
);
	import adl64_pkg::*;

	logic [LOW_W-1:0]  seed_lo;
	logic [HIGH_W-1:0] seed_hi;
	logic [LOW_W-1:0]  a_base;
	logic [HIGH_W-1:0] b_base;
	logic [LOW_W:0]    a_sum;
	logic [LOW_W:0]    b_sum;
	logic [HIGH_W:0]   b_fold;

	// Seed parts are below twice their modulus: one conditional subtract.
	assign seed_lo = (item.seed[LOW_W-1:0] >= LOW_MOD) ?
		item.seed[LOW_W-1:0] - LOW_MOD : item.seed[LOW_W-1:0];
	assign seed_hi = (item.seed[SEED_W-1:LOW_W] == HIGH_MOD) ?
		'0 : item.seed[SEED_W-1:LOW_W];

	assign a_base = item.first ? seed_lo : cur.low;
	assign b_base = item.first ? seed_hi : cur.high;

	// a + word < 2 * LOW_MOD
	assign a_sum   = {1'b0, a_base} + {{(LOW_W+1-WORD_W){1'b0}}, item.word};
	assign nxt.low = (a_sum >= {1'b0, LOW_MOD}) ?
		LOW_W'(a_sum - {1'b0, LOW_MOD}) : a_sum[LOW_W-1:0];

	// b + a < 2^33; fold at bit 31 since 2^31 = 1 mod HIGH_MOD
	assign b_sum  = {{(LOW_W+1-HIGH_W){1'b0}}, b_base} + {1'b0, nxt.low};
	assign b_fold = {1'b0, b_sum[HIGH_W-1:0]}
		+ {{(2*HIGH_W-LOW_W){1'b0}}, b_sum[LOW_W:HIGH_W]};
	assign nxt.high = (b_fold >= {1'b0, HIGH_MOD}) ?
		HIGH_W'(b_fold - {1'b0, HIGH_MOD}) : b_fold[HIGH_W-1:0];
endmodule

[sv/adl64_out_reg.sv]
// ----------------------------------------------------------------------------
// adl64_out_reg
// Result register on the checksum channel; frees itself as it drains.
// ----------------------------------------------------------------------------
module adl64_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  adl64_pkg::sums_t      sums,
	output logic                  free,
	adl64_sum_if.source           sum_out
);
	import adl64_pkg::*;

	logic                    valid_q;
	logic [HIGH_W+LOW_W-1:0] checksum_q;

	assign free = !valid_q || sum_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			checksum_q <= {sums.high, sums.low};
		end
	end

	assign sum_out.valid    = valid_q;
	assign sum_out.checksum = checksum_q;
endmodule

[sv/adler64_word_checksum.sv]
// ----------------------------------------------------------------------------
// adler64_word_checksum
// Adler-style 64-bit checksum over a stream of 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   words carries one 32-bit word per transaction (first byte in bits 31:24).
//   first loads seed before the word is added: seed[32:0] to the low sum,
//   seed[63:33] to the high sum, each reduced by its modulus. last closes
//   the block and yields one transaction on sums: checksum = {high, low}.
//   A word after last without first keeps chaining from the emitted sums.
// Timing:
//   A word is registered in the input stage at acceptance. When it retires,
//   it is folded into the sums; a last word's checksum loads into the output
//   register on that same edge and drives sums.valid. One word per cycle while
//   no last word waits on that register; the sum update loop sets the rate.
// Reset:
//   arst_n clears both sums to zero and empties both registers.
// Stalls:
//   Plain words keep flowing while a checksum waits in the output register.
//   A word with last holds in the input stage until that register frees,
//   and words.ready drops meanwhile; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "adler64_word_checksum_macros.svh"

module adler64_word_checksum (
	input  logic          clk,
	input  logic          arst_n,
	adl64_word_if.sink    words,
	adl64_sum_if.source   sums
);
	import adl64_pkg::*;

	// Input stage
	logic       valid_s1;
	word_item_t item_s1;

	// Running sums
	logic [LOW_W-1:0]  low_sum_q;
	logic [HIGH_W-1:0] high_sum_q;

	sums_t    cur_sums;
	sums_t    nxt_sums;
	out_ctl_t out_ctl;
	logic     advance;

	// Check terms
	logic     last_stall;
	logic     out_match;

	assign cur_sums.low  = low_sum_q;
	assign cur_sums.high = high_sum_q;

	// Input stage retires when the output register can take its checksum
	// (only needed for a last word).
	assign advance      = valid_s1 && (!item_s1.last || out_ctl.free);
	assign out_ctl.load = advance && item_s1.last;
	assign words.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (words.ready) begin
			valid_s1 <= words.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (words.ready && words.valid) begin
			item_s1.word  <= words.word;
			item_s1.first <= words.first;
			item_s1.seed  <= words.seed;
			item_s1.last  <= words.last;
		end
	end

	adl64_sum_update u_update (
		.item (item_s1),
		.cur  (cur_sums),
		.nxt  (nxt_sums)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_sum_q  <= '0;
			high_sum_q <= '0;
		end else if (advance) begin
			low_sum_q  <= nxt_sums.low;
			high_sum_q <= nxt_sums.high;
		end
	end

	adl64_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (out_ctl.load),
		.sums    (nxt_sums),
		.free    (out_ctl.free),
		.sum_out (sums)
	);

	assign last_stall = valid_s1 && item_s1.last && sums.valid && !sums.ready;
	assign out_match  = sums.valid && (sums.checksum == cur_sums);

	// Sums stay reduced
	`ADL64_ASSERT(a_low_reduced, low_sum_q < LOW_MOD, "low sum not reduced")
	`ADL64_ASSERT(a_high_reduced, high_sum_q < HIGH_MOD, "high sum not reduced")
	// A last word waits while the result register is stalled
	`ADL64_ASSERT_NEXT(a_last_holds, last_stall, valid_s1 && item_s1.last, "last word lost")
	// Emitted checksum matches the sums it leaves behind
	`ADL64_ASSERT_NEXT(a_result_match, out_ctl.load, out_match, "checksum does not match sums")
endmodule

[test/tb_adler64_word_checksum.sv]
// ----------------------------------------------------------------------------
// tb_adler64_word_checksum
// Self-checking bench for the 64-bit word checksum. A queue of word
// transactions (directed corner cases, then random blocks) feeds a clocked
// driver; each accepted word is folded into a local copy of the sums, and
// every word with last queues the checksum that the output channel must
// deliver next. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_adler64_word_checksum;
	timeunit 1ns;
	timeprecision 1ps;

	import adl64_pkg::*;

	localparam int unsigned TIMEOUT_CYCLES = 400000;
	// Minimum words per random phase; the sender drains between the two phases
	localparam int unsigned PHASE_WORDS    = 275;
	// Input register plus output register, with margin
	localparam int unsigned TAIL_CYCLES    = 8;

	logic clk = 1'b0;
	logic arst_n;

	adl64_word_if words_if ();
	adl64_sum_if  sums_if ();

	adler64_word_checksum uut (
		.clk    (clk),
		.arst_n (arst_n),
		.words  (words_if),
		.sums   (sums_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Bench state
	// ------------------------------------------------------------------
	word_item_t        word_queue[$];    // word transactions not yet driven
	logic [63:0]       expected_sums[$]; // checksums owed by the block, in order
	word_item_t        cur_item;         // transaction currently on the bus
	logic [LOW_W-1:0]  low_sum;          // local copy of the running sums
	logic [HIGH_W-1:0] high_sum;
	int unsigned       err_cnt;
	int unsigned       cycles;
	int unsigned       calm_left;        // while nonzero, nobody idles
	int unsigned       send_gap;
	int unsigned       stall_left;

	// ------------------------------------------------------------------
	// Sum update: optional seed load, then low sum, then high sum.
	// Both parts of the seed are reduced on load, so a high part equal
	// to its modulus loads as zero. Seed is ignored without first.
	// ------------------------------------------------------------------
	task automatic fold_word(input word_item_t it);
		logic [63:0] lo;
		logic [63:0] hi;
		lo = {31'd0, low_sum};
		hi = {33'd0, high_sum};
		if (it.first) begin
			lo = {31'd0, it.seed[LOW_W-1:0]} % {31'd0, LOW_MOD};
			hi = {33'd0, it.seed[SEED_W-1:LOW_W]} % {33'd0, HIGH_MOD};
		end
		lo = (lo + {32'd0, it.word}) % {31'd0, LOW_MOD};
		hi = (hi + lo) % {33'd0, HIGH_MOD};
		low_sum  = lo[LOW_W-1:0];
		high_sum = hi[HIGH_W-1:0];
		if (it.last)
			expected_sums.push_back({high_sum, low_sum});
	endtask

	// Idle length: mostly none, some short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm_left != 0) return 0;
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [WORD_W-1:0] rand_word();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return $urandom;
	endfunction

	// Seeds lean toward parts at or next to their moduli
	function automatic logic [SEED_W-1:0] rand_seed();
		int unsigned r;
		logic [SEED_W-1:0] s;
		r = $urandom_range(0, 9);
		s = {$urandom, $urandom};
		if (r == 0) return '0;
		if (r == 1) return '1;
		if (r == 2) s[SEED_W-1:LOW_W] = HIGH_MOD - $urandom_range(0, 1);
		if (r == 3) s[LOW_W-1:0] = LOW_MOD + $urandom_range(0, 3) - 1;
		return s;
	endfunction

	task automatic push_item(input logic [WORD_W-1:0] w, input logic f,
			input logic [SEED_W-1:0] s, input logic l);
		word_item_t it;
		it.word  = w;
		it.first = f;
		it.seed  = s;
		it.last  = l;
		word_queue.push_back(it);
	endtask

	// One block of words. Most blocks start with a seed; the rest chain
	// from the previous checksum. A few carry a stray first mid-block.
	task automatic queue_block(input int unsigned len);
		logic seeded;
		seeded = ($urandom_range(0, 9) < 8);
		for (int unsigned i = 0; i < len; i++)
			push_item(rand_word(),
				(i == 0) ? seeded : ($urandom_range(0, 31) == 0),
				rand_seed(), (i == len - 1));
	endtask

	function automatic int unsigned pick_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 4);
		if (r < 95) return $urandom_range(5, 16);
		return $urandom_range(17, 48);
	endfunction

	// Hold off until every queued word is accepted and every checksum seen
	task automatic wait_drained();
		while (word_queue.size() != 0 || words_if.valid || expected_sums.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Cycle counter and the no-idle stretches shared by both sides
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycles    <= 0;
			calm_left <= 0;
		end else begin
			cycles <= cycles + 1;
			if (calm_left != 0)
				calm_left <= calm_left - 1;
			else if ($urandom_range(0, 499) == 0)
				calm_left <= $urandom_range(50, 200);
		end
	end

	// ------------------------------------------------------------------
	// Driver: a transaction stays on the bus until words.ready takes it.
	// At acceptance the word is folded into the local sums; the next one
	// comes off the queue after a random gap.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_if.valid <= 1'b0;
			words_if.word  <= '0;
			words_if.first <= 1'b0;
			words_if.seed  <= '0;
			words_if.last  <= 1'b0;
			cur_item       <= '0;
			send_gap       <= 0;
			low_sum        = '0;
			high_sum       = '0;
		end else if (!(words_if.valid && !words_if.ready)) begin
			if (words_if.valid)
				fold_word(cur_item);
			if (send_gap != 0) begin
				words_if.valid <= 1'b0;
				send_gap       <= send_gap - 1;
			end else if (word_queue.size() != 0) begin
				cur_item       <= word_queue[0];
				words_if.word  <= word_queue[0].word;
				words_if.first <= word_queue[0].first;
				words_if.seed  <= word_queue[0].seed;
				words_if.last  <= word_queue[0].last;
				words_if.valid <= 1'b1;
				word_queue.pop_front();
				send_gap       <= pick_gap();
			end else begin
				words_if.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: every checksum transaction must match the oldest owed one.
	// Ready drops for random stretches independent of traffic.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_if.ready <= 1'b0;
			stall_left    <= 0;
		end else begin
			if (sums_if.valid && sums_if.ready) begin
				if (expected_sums.size() == 0) begin
					$error("checksum: unexpected transaction %h", sums_if.checksum);
					err_cnt++;
				end else begin
					if (sums_if.checksum !== expected_sums[0]) begin
						$error("checksum: expected %h, actual %h",
							expected_sums[0], sums_if.checksum);
						err_cnt++;
					end
					expected_sums.pop_front();
				end
			end
			if (stall_left != 0) begin
				sums_if.ready <= 1'b0;
				stall_left    <= stall_left - 1;
			end else begin
				sums_if.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left <= pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int unsigned n;
		words_if.valid = 1'b0;
		words_if.word  = '0;
		words_if.first = 1'b0;
		words_if.seed  = '0;
		words_if.last  = 1'b0;
		sums_if.ready  = 1'b0;
		err_cnt        = 0;
		arst_n         = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// No seed after reset: sums start from zero
		push_item('1, 1'b0, '0, 1'b0);
		push_item(32'h1234_5678, 1'b0, '0, 1'b1);
		// Word after last without first chains from the emitted sums
		push_item(32'h0000_0001, 1'b0, '0, 1'b1);
		// Seed with first clear is ignored
		push_item(32'hdead_beef, 1'b0, '1, 1'b1);
		// First and last on one word, all-ones seed: both parts reduce
		push_item('1, 1'b1, '1, 1'b1);
		// Seed parts exactly at the moduli load as zero
		push_item('0, 1'b1, {HIGH_MOD, LOW_MOD}, 1'b0);
		push_item('0, 1'b0, '0, 1'b1);
		// Zero seed, zero word
		push_item('0, 1'b1, '0, 1'b1);
		// Seed parts one below their moduli: both sums wrap as the word is added
		push_item('1, 1'b1, {HIGH_MOD - 31'd1, LOW_MOD - 33'd1}, 1'b1);
		push_item(32'h8000_0000, 1'b1, {HIGH_MOD - 31'd1, LOW_MOD - 33'd1}, 1'b0);
		push_item(32'h7fff_ffff, 1'b0, 64'h5555_5555_5555_5555, 1'b1);
		// Run of all-ones words keeps the low sum wrapping
		for (int i = 0; i < 8; i++)
			push_item('1, (i == 0), 64'haaaa_aaaa_aaaa_aaaa, (i == 7));
		// Alternating bit patterns in word and seed
		push_item(32'h5555_5555, 1'b1, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
		push_item(32'haaaa_aaaa, 1'b0, 64'h5555_5555_5555_5555, 1'b1);
		// Restart with first inside an open block
		push_item(32'h0f0f_0f0f, 1'b1, 64'h0123_4567_89ab_cdef, 1'b0);
		push_item(32'hf0f0_f0f0, 1'b1, 64'hfedc_ba98_7654_3210, 1'b1);
		wait_drained();

		n = 0;
		while (n < PHASE_WORDS) begin
			int unsigned len;
			len = pick_len();
			queue_block(len);
			n += len;
		end
		// Sender holds until the phase has drained, then goes again
		wait_drained();

		n = 0;
		while (n < PHASE_WORDS) begin
			int unsigned len;
			len = pick_len();
			queue_block(len);
			n += len;
		end
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (err_cnt == 0)
			$display("tb_adler64_word_checksum: clean");
		else
			$display("tb_adler64_word_checksum: errors");
		$finish;
	end

	// Watchdog on the cycle counter
	initial begin
		wait (arst_n === 1'b1 && cycles >= TIMEOUT_CYCLES);
		$display("tb_adler64_word_checksum: errors");
		$finish;
	end

endmodule
